// File: rtl/core/ile_pkg.sv
// Package: shared constants, codes, types and sizing functions of the indexed list engine.
package ile_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned OP_W         = 3;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned ENTRY_W      = 11;
    // slot index width that covers the largest supported capacity
    localparam int unsigned AT_W         = 16;
    localparam int unsigned FANIN        = 32;

    typedef enum logic [OP_W-1:0] {
        OP_READ       = 3'd0,
        OP_INS_FRONT  = 3'd1,
        OP_INS_BACK   = 3'd2,
        OP_INS_AT     = 3'd3,
        OP_DELETE     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // broadcast to every slot cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              rd;
        logic [AT_W-1:0]   at;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

    // node count of reduction level l (level 0 = leaves)
    function automatic int unsigned tree_width(input int unsigned n, input int unsigned l);
        int unsigned w;
        w = n;
        for (int unsigned i = 0; i < l; i++)
        begin
            w = (w + FANIN - 1) / FANIN;
        end
        return w;
    endfunction

    function automatic int unsigned tree_levels(input int unsigned n);
        int unsigned w;
        int unsigned l;
        w = n;
        l = 0;
        while (w > 1)
        begin
            w = (w + FANIN - 1) / FANIN;
            l++;
        end
        return l;
    endfunction

endpackage

// File: rtl/core/ile_if.sv
// Interfaces: request and response channels of the indexed list engine.
interface ile_req_if;
    logic                             valid;
    logic                             ready;
    logic [ile_pkg::OP_W-1:0]         op;
    logic signed [ile_pkg::DATA_W-1:0] position;
    logic signed [ile_pkg::DATA_W-1:0] data_value;

    modport source (output valid, output op, output position, output data_value, input ready);
    modport sink   (input valid, input op, input position, input data_value, output ready);
endinterface

interface ile_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [ile_pkg::DATA_W-1:0] read_value;
    logic [ile_pkg::STATUS_W-1:0]      status;
    logic [ile_pkg::ENTRY_W-1:0]       entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input entry_count,
                    output ready);
endinterface

// File: rtl/core/ile_cell.sv
// One slot cell: holds a list entry, shifts with its neighbors, offers it on a read.
module ile_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                      clk,
    input  ile_pkg::cell_cmd_t        cmd,
    input  logic [ile_pkg::DATA_W-1:0] lower,
    input  logic [ile_pkg::DATA_W-1:0] upper,
    output logic [ile_pkg::DATA_W-1:0] value,
    output logic [ile_pkg::DATA_W-1:0] leaf
);
    import ile_pkg::*;

    localparam logic [AT_W-1:0] IDX = AT_W'(INDEX);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic [DATA_W-1:0] leaf_reg;
    logic [DATA_W-1:0] leaf_next;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (IDX > cmd.at)
                value_next = lower;
            else if (IDX == cmd.at)
                value_next = cmd.data;
        end
        else if (cmd.del && IDX >= cmd.at)
        begin
            value_next = upper;
        end
        // only the addressed cell puts its value on the gather tree
        leaf_next = (cmd.rd && IDX == cmd.at) ? value_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        leaf_reg  <= leaf_next;
    end

    assign value = value_reg;
    assign leaf  = leaf_reg;

endmodule

// File: rtl/core/ile_or_tree.sv
// Registered OR reduction tree that gathers the one nonzero read leaf.
module ile_or_tree #(
    parameter int unsigned N = ile_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic [ile_pkg::DATA_W-1:0] leaf [N],
    output logic [ile_pkg::DATA_W-1:0] root
);
    import ile_pkg::*;

    localparam int unsigned LEVELS = tree_levels(N);
    // widest level above the leaves
    localparam int unsigned L1_W   = tree_width(N, 1);

    logic [DATA_W-1:0] lvl_reg [LEVELS][L1_W];

    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_lvl
        localparam int unsigned PW = tree_width(N, l - 1);
        localparam int unsigned CW = tree_width(N, l);
        for (genvar j = 0; j < CW; j++)
        begin : g_node
            localparam int unsigned KN = (PW - j * FANIN < FANIN) ? PW - j * FANIN : FANIN;
            logic [DATA_W-1:0] acc;
            if (l == 1)
            begin : g_leaf
                always_comb
                begin
                    acc = '0;
                    for (int unsigned k = 0; k < KN; k++)
                    begin
                        acc = acc | leaf[j * FANIN + k];
                    end
                end
            end
            else
            begin : g_inner
                always_comb
                begin
                    acc = '0;
                    for (int unsigned k = 0; k < KN; k++)
                    begin
                        acc = acc | lvl_reg[l - 2][j * FANIN + k];
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                lvl_reg[l - 1][j] <= acc;
            end
        end
    end

    assign root = lvl_reg[LEVELS - 1][0];

endmodule

// File: rtl/core/indexed_list_engine.sv
// Top level: indexed list engine built as a row of slot cells with a read gather tree.
//
// Usage notes
//  - req channel (valid/ready): one item = op, position, data_value. Accepted on a
//    rising edge with valid and ready high.
//  - rsp channel (valid/ready): one item per request = read_value, status, entry_count.
//  - Insert and delete act on all CAPACITY cells at once: on insert each cell above the
//    target takes its lower neighbor (the target cell takes the new value); on delete
//    each cell at or above it takes its upper neighbor. These and rejected requests give
//    their result the cycle after accept, at one item per cycle unless rsp.ready stalls.
//  - A successful read gathers the addressed cell through a registered OR tree of
//    fan-in 32 with LEVELS = ceil(log32(CAPACITY)) levels. The value passes the leaf
//    register and each tree level into the response register; no new item is taken
//    until the result is registered, so a read does not overlap with other items.
//  - The response register is separate from the request side: a new item is taken
//    while a result waits, as long as that result is consumed in the same cycle.
//    If rsp.ready stays low, req.ready drops and nothing is lost.
//  - Reset (rst_n low, async) empties the list; slot contents are left as they are
//    and are never read before being written.
module indexed_list_engine #(
    parameter int unsigned CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input logic clk,
    input logic rst_n,
    ile_req_if.sink   req,
    ile_rsp_if.source rsp
);
    import ile_pkg::*;

    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned LEVELS = tree_levels(CAPACITY);
    localparam int unsigned LVL_W  = $clog2(LEVELS + 1);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  len_next;
    logic [LVL_W-1:0]  lvl_cnt_reg;
    logic [LVL_W-1:0]  lvl_cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] rv_reg;
    logic [DATA_W-1:0] rv_next;
    status_t           st_reg;
    status_t           st_next;
    logic [ENTRY_W-1:0] ec_reg;
    logic [ENTRY_W-1:0] ec_next;

    logic              fire;
    logic              out_free;
    logic              pos_lt;
    logic              pos_le;
    logic              full;
    logic [30:0]       len_ext;
    cell_cmd_t         cmd;
    status_t           res_st;
    logic [DATA_W-1:0] root;

    logic [DATA_W-1:0] slot_val [CAPACITY];
    logic [DATA_W-1:0] leaf     [CAPACITY];

    // ---------------------------------------------------------------
    // request decode
    // ---------------------------------------------------------------
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign fire      = req.valid && req.ready;

    assign len_ext = 31'(len_reg);
    assign pos_lt  = !req.position[31] && (req.position[30:0] < len_ext);
    assign pos_le  = !req.position[31] && (req.position[30:0] <= len_ext);
    assign full    = (len_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        cmd      = '0;
        cmd.data = req.data_value;
        cmd.at   = req.position[AT_W-1:0];
        res_st   = ST_DONE;
        unique case (req.op)
            OP_READ:
            begin
                if (pos_lt)
                    cmd.rd = fire;
                else
                    res_st = ST_INVALID;
            end
            OP_INS_FRONT:
            begin
                cmd.at = '0;
                if (full)
                    res_st = ST_FULL;
                else
                    cmd.ins = fire;
            end
            OP_INS_BACK:
            begin
                cmd.at = AT_W'(len_reg);
                if (full)
                    res_st = ST_FULL;
                else
                    cmd.ins = fire;
            end
            OP_INS_AT:
            begin
                if (!pos_le)
                    res_st = ST_INVALID;
                else if (full)
                    res_st = ST_FULL;
                else
                    cmd.ins = fire;
            end
            OP_DELETE:
            begin
                if (pos_lt)
                    cmd.del = fire;
                else
                    res_st = ST_INVALID;
            end
            default:
            begin
                res_st = ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.ins)
            len_next = len_reg + CNT_W'(1);
        else if (cmd.del)
            len_next = len_reg - CNT_W'(1);
    end

    // ---------------------------------------------------------------
    // slot cells: each one talks to its two neighbors
    // ---------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
        if (i == 0)
        begin : g_bot
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = slot_val[i - 1];
        end
        if (i == CAPACITY - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = slot_val[i + 1];
        end

        ile_cell #(
            .INDEX (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .lower (lower),
            .upper (upper),
            .value (slot_val[i]),
            .leaf  (leaf[i])
        );
    end

    ile_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .clk  (clk),
        .leaf (leaf),
        .root (root)
    );

    // ---------------------------------------------------------------
    // control: idle takes items, read waits for the gather tree
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        lvl_cnt_next   = lvl_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rv_next        = rv_reg;
        st_next        = st_reg;
        ec_next        = ec_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    if (cmd.rd)
                    begin
                        state_next   = S_READ;
                        lvl_cnt_next = '0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        rv_next        = '1;
                        st_next        = res_st;
                        ec_next        = ENTRY_W'(len_next);
                    end
                end
            end
            S_READ:
            begin
                if (lvl_cnt_reg == LVL_W'(LEVELS))
                begin
                    if (out_free)
                    begin
                        state_next     = S_IDLE;
                        out_valid_next = 1'b1;
                        rv_next        = root;
                        st_next        = ST_DONE;
                        ec_next        = ENTRY_W'(len_reg);
                    end
                end
                else
                begin
                    lvl_cnt_next = lvl_cnt_reg + LVL_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            lvl_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            lvl_cnt_reg   <= lvl_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg <= rv_next;
        st_reg <= st_next;
        ec_reg <= ec_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = rv_reg;
    assign rsp.status      = st_reg;
    assign rsp.entry_count = ec_reg;

`ifndef SYNTH
    // the list never grows past its store
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    // length only moves on an accepted item
    a_len_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != $past(len_reg)) |-> $past(fire))
        else $error("list length changed without a request");

    // anything but a successful read reports all ones; checked here for failed requests
    a_no_value_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && st_reg != ST_DONE) |-> (rv_reg == '1))
        else $error("failed request carries a read value");

    // a pending result is not overwritten
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(rv_reg)
                                           && $stable(ec_reg)))
        else $error("pending result lost");
`endif

endmodule

// File: tb/indexed_list_engine_tb.sv
// Testbench for indexed_list_engine: directed and random list traffic checked against an in-bench list model.
module indexed_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    // Block under test keeps its default size; the fill phase takes it to full once.
    localparam int unsigned SLOTS        = CAPACITY_DEF;
    // Ops past OP_DELETE are unassigned; the block must reject them.
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [DATA_W-1:0] NO_VALUE     = '1;
    localparam logic [DATA_W-1:0] MOST_NEG     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS     = 32'h7fff_ffff;
    // Receiver hold-off: starts on this result, during the fill, while the sender keeps going.
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 500;
    // Settle time after the last result, longer than a read takes at this size.
    localparam int unsigned SETTLE       = 16;
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned REPORT_MAX   = 10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] position;
        logic [DATA_W-1:0] data_value;
    } list_request_t;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        status_t            status;
        logic [ENTRY_W-1:0] count;
    } list_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    ile_req_if req();
    ile_rsp_if rsp();

    indexed_list_engine #(
        .CAPACITY(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    always #4 clk = ~clk;

    // Shadow copy of the list, entry 0 at the front.
    logic [DATA_W-1:0] list_model[$];

    list_request_t queued_requests[$];
    list_reply_t   awaited_replies[$];
    list_request_t on_bus;

    // Length the list will have once everything queued so far has run; used only to
    // aim positions while generating, the checking side never looks at it.
    int unsigned planned_len;
    int unsigned requests_queued;
    int unsigned requests_taken;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned cycles;

    int unsigned gap_left;
    int unsigned sender_wait;
    bit          sender_bursting;
    int unsigned stall_left;
    int unsigned receiver_wait;
    bit          receiver_bursting;

    // Applies one request to the shadow list and returns the reply it must produce.
    function automatic list_reply_t apply_to_list(input list_request_t r);
        list_reply_t reply;
        int unsigned len;
        bit          off_list;
        len = list_model.size();
        off_list = r.position[DATA_W-1];
        reply.value = NO_VALUE;
        reply.status = ST_DONE;
        case (r.op)
            OP_READ:
            begin
                if (off_list || r.position >= len)
                    reply.status = ST_INVALID;
                else
                    reply.value = list_model[r.position];
            end
            OP_INS_FRONT:
            begin
                if (len >= SLOTS)
                    reply.status = ST_FULL;
                else
                    list_model.push_front(r.data_value);
            end
            OP_INS_BACK:
            begin
                if (len >= SLOTS)
                    reply.status = ST_FULL;
                else
                    list_model.push_back(r.data_value);
            end
            OP_INS_AT:
            begin
                // range check wins over the full check
                if (off_list || r.position > len)
                    reply.status = ST_INVALID;
                else if (len >= SLOTS)
                    reply.status = ST_FULL;
                else
                    list_model.insert(r.position, r.data_value);
            end
            OP_DELETE:
            begin
                if (off_list || r.position >= len)
                    reply.status = ST_INVALID;
                else
                    list_model.delete(r.position);
            end
            default:
            begin
                reply.status = ST_INVALID;
            end
        endcase
        len = list_model.size();
        reply.count = len[ENTRY_W-1:0];
        return reply;
    endfunction

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] pos,
                                 input logic [DATA_W-1:0] data);
        list_request_t r;
        r.op = op;
        r.position = pos;
        r.data_value = data;
        queued_requests.push_back(r);
        requests_queued++;
        // keep the generator's idea of the length in step
        case (op)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                if (planned_len < SLOTS)
                    planned_len++;
            end
            OP_INS_AT:
            begin
                if (!pos[DATA_W-1] && pos <= planned_len && planned_len < SLOTS)
                    planned_len++;
            end
            OP_DELETE:
            begin
                if (!pos[DATA_W-1] && pos < planned_len)
                    planned_len--;
            end
            default:
            begin
            end
        endcase
    endtask

    // One random request. Most positions land on the list (ends favored); a few are
    // negative or far past the end, and a few ops are unassigned codes.
    task automatic queue_random(input int unsigned ins_pct, input int unsigned del_pct);
        int unsigned       pick;
        int unsigned       top;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] pos;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct)
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_INS_FRONT;
                1:       op = OP_INS_BACK;
                default: op = OP_INS_AT;
            endcase
        end
        else if (pick < ins_pct + del_pct)
            op = OP_DELETE;
        else
            op = OP_READ;
        if ($urandom_range(0, 99) < 3)
            op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

        if (op == OP_INS_AT)
            top = planned_len;
        else
            top = (planned_len == 0) ? 0 : planned_len - 1;
        pos = $urandom_range(0, top);
        if ($urandom_range(0, 7) == 0)
            pos = top;
        else if ($urandom_range(0, 7) == 0)
            pos = 0;

        if ($urandom_range(0, 99) < 6)
        begin
            if ($urandom_range(0, 1) == 0)
                pos = $urandom() | MOST_NEG;
            else
                pos = $urandom_range(MOST_POS, SLOTS + 1);
        end
        queue_request(op, pos, $urandom());
    endtask

    // Sender pause: hold off until every queued item is taken and answered.
    task automatic drain();
        while (requests_taken != requests_queued || awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    // Driver: presents queued items, with a randomly drawn idle gap after each
    // accepted one. Bursting stretches run with no gaps at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            sender_wait = gap_left;
            if (req.valid && req.ready)
            begin
                awaited_replies.push_back(apply_to_list(on_bus));
                requests_taken++;
                if ($urandom_range(0, 39) == 0)
                    sender_bursting = !sender_bursting;
                sender_wait = sender_bursting ? 0 : $urandom_range(0, 7);
            end
            if (!req.valid || req.ready)
            begin
                if (sender_wait != 0)
                begin
                    gap_left <= sender_wait - 1;
                    req.valid <= 1'b0;
                end
                else if (queued_requests.size() != 0)
                begin
                    on_bus <= queued_requests[0];
                    req.op <= queued_requests[0].op;
                    req.position <= queued_requests[0].position;
                    req.data_value <= queued_requests[0].data_value;
                    void'(queued_requests.pop_front());
                    gap_left <= 0;
                    req.valid <= 1'b1;
                end
                else
                begin
                    gap_left <= 0;
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every reply against the oldest prediction, then drops ready for a
    // randomly drawn stretch. One long hold-off backs the block up into its request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("reply %0d with none awaited: value %h status %0d count %0d",
                                 results_seen, rsp.read_value, rsp.status, rsp.entry_count);
                end
                else
                begin
                    if (rsp.read_value !== awaited_replies[0].value
                        || rsp.status !== awaited_replies[0].status
                        || rsp.entry_count !== awaited_replies[0].count)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("reply %0d: value %h/%h status %0d/%0d count %0d/%0d %s",
                                     results_seen, awaited_replies[0].value, rsp.read_value,
                                     awaited_replies[0].status, rsp.status,
                                     awaited_replies[0].count, rsp.entry_count,
                                     "(expected/actual)");
                    end
                    void'(awaited_replies.pop_front());
                end
                results_seen++;
                if ($urandom_range(0, 39) == 0)
                    receiver_bursting = !receiver_bursting;
                if (results_seen == HOLD_AT)
                    receiver_wait = HOLD_CYCLES;
                else
                    receiver_wait = receiver_bursting ? 0 : $urandom_range(0, 7);
                stall_left <= receiver_wait;
                rsp.ready <= (receiver_wait == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                rsp.ready <= (stall_left == 1);
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hang or a lost reply ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        planned_len = 0;
        requests_queued = 0;
        requests_taken = 0;
        results_seen = 0;
        mismatches = 0;
        sender_bursting = 1'b0;
        receiver_bursting = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.op = '0;
        req.position = '0;
        req.data_value = '0;
        rsp.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-list rejects, appends at the count, value extremes,
        // out-of-range positions on both sides, unassigned ops, deletes at
        // the last, first and a middle entry.
        queue_request(OP_READ, 0, 0);
        queue_request(OP_DELETE, 0, 0);
        queue_request(OP_INS_AT, 1, 32'h1234_5678);
        queue_request(OP_INS_AT, NO_VALUE, 32'h1234_5678);
        queue_request(OP_INS_AT, 0, MOST_POS);
        queue_request(OP_INS_FRONT, MOST_POS, MOST_NEG);
        queue_request(OP_INS_BACK, MOST_NEG, NO_VALUE);
        queue_request(OP_INS_AT, 3, 0);
        queue_request(OP_INS_AT, 2, 32'h5555_5555);
        queue_request(OP_READ, 0, NO_VALUE);
        queue_request(OP_READ, 4, 0);
        queue_request(OP_READ, 5, 0);
        queue_request(OP_READ, MOST_POS, 0);
        queue_request(OP_READ, MOST_NEG, 0);
        queue_request(OP_READ, NO_VALUE, 0);
        queue_request(OP_SPARE_FIRST, 0, 32'haaaa_aaaa);
        queue_request(OP_SPARE_MID, 1, 32'h0f0f_0f0f);
        queue_request(OP_SPARE_LAST, NO_VALUE, NO_VALUE);
        queue_request(OP_DELETE, MOST_NEG, 0);
        queue_request(OP_DELETE, 5, 0);
        queue_request(OP_DELETE, 4, 0);
        queue_request(OP_DELETE, 0, 0);
        queue_request(OP_READ, 1, 0);
        queue_request(OP_DELETE, 1, 0);
        queue_request(OP_READ, 0, 0);
        drain();

        // Fill: insert-heavy traffic with reads and deletes mixed in, until the
        // store is full. The long receiver hold-off lands in here.
        while (planned_len < SLOTS)
            queue_random(97, 1);
        drain();

        // Full store: every insert form is dropped, except that an out-of-range insert-at still
        // reports the bad position; a delete then frees one slot that an insert-at refills.
        queue_request(OP_INS_FRONT, 0, $urandom());
        queue_request(OP_INS_BACK, 0, $urandom());
        queue_request(OP_INS_AT, SLOTS, $urandom());
        queue_request(OP_INS_AT, SLOTS + 1, $urandom());
        queue_request(OP_INS_AT, MOST_NEG, $urandom());
        queue_request(OP_READ, SLOTS - 1, 0);
        queue_request(OP_READ, SLOTS, 0);
        queue_request(OP_DELETE, SLOTS - 1, 0);
        queue_request(OP_INS_AT, SLOTS - 1, $urandom());
        queue_request(OP_INS_BACK, 0, $urandom());
        queue_request(OP_DELETE, 0, 0);
        queue_request(OP_READ, 0, 0);

        // Mixed traffic around the full mark and below it.
        repeat (30)
            queue_random(40, 40);

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: indexed_list_engine.f
rtl/core/ile_pkg.sv
rtl/core/ile_if.sv
rtl/core/ile_cell.sv
rtl/core/ile_or_tree.sv
rtl/core/indexed_list_engine.sv
tb/indexed_list_engine_tb.sv
